// ----- src/mcct_pkg.sv -----
// Package for the multi-channel countdown timer block.
// Holds the table size, command and result codes, and the queued command type.
// No dependencies.
package mcct_pkg;

	localparam int TIMER_COUNT = 8;
	localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
	localparam int CNT_W = $clog2(TIMER_COUNT + 1);
	localparam int HANDLE_W = 3;
	localparam int MODE_W = 3;
	localparam int KIND_W = 2;
	localparam int DATA_W = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [MODE_W-1:0] MODE_TICK  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ALLOC = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SET   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_START = 3'd3;
	localparam logic [MODE_W-1:0] MODE_STOP  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_RESET = 3'd5;
	localparam logic [MODE_W-1:0] MODE_READ  = 3'd6;

	localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd0;
	localparam logic [KIND_W-1:0] KIND_GRANT  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REFUSE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_TICKS  = 2'd3;

	typedef enum logic [2:0] {
		OP_TICK,
		OP_ALLOC,
		OP_SET,
		OP_START,
		OP_STOP,
		OP_RESET,
		OP_READ
	} cmd_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} back_state_t;

	typedef struct packed {
		cmd_op_t             op;
		logic [IDX_W-1:0]    idx;
		logic [DATA_W-1:0]   period;
		logic                one_shot;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} queue_status_t;

endpackage

// ----- src/mcct_front.sv -----
// Front end of the timer block: decodes each request into a queued command.
// Requests that have no effect are dropped here. Uses mcct_pkg.
module mcct_front
	import mcct_pkg::*;
(
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [MODE_W-1:0]   mode,
	input  logic [HANDLE_W-1:0] handle,
	input  logic [DATA_W-1:0]   period,
	input  logic                one_shot,
	input  queue_status_t       q_status,
	output logic                push,
	output cmd_t                push_cmd
);

	logic    keep;
	logic    h_ok;
	cmd_op_t op;

	always_comb begin
		h_ok = (32'(handle) < 32'(TIMER_COUNT));
		keep = 1'b1;
		op = OP_TICK;
		case (mode)
			MODE_TICK: op = OP_TICK;
			MODE_ALLOC: op = OP_ALLOC;
			MODE_SET: begin
				op = OP_SET;
				keep = h_ok;
			end
			MODE_START: begin
				op = OP_START;
				keep = h_ok;
			end
			MODE_STOP: begin
				op = OP_STOP;
				keep = h_ok;
			end
			MODE_RESET: begin
				op = OP_RESET;
				keep = h_ok;
			end
			MODE_READ: op = OP_READ;
			default: keep = 1'b0;
		endcase
		in_stall = q_status.full;
		push = in_valid && !q_status.full && keep;
		push_cmd.op = op;
		push_cmd.idx = IDX_W'(handle);
		push_cmd.period = period;
		push_cmd.one_shot = one_shot;
	end

endmodule

// ----- src/mcct_queue.sv -----
// Short command queue between the front end and the timer engine.
// Uses mcct_pkg for the command type and depth.
module mcct_queue
	import mcct_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cmd_t          push_cmd,
	input  logic          pop,
	output cmd_t          head,
	output queue_status_t status
);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_comb begin
		head = mem_q[rd_ptr_q];
		status.full = (count_q == QCNT_W'(QUEUE_DEPTH));
		status.not_empty = (count_q != '0);
	end

endmodule

// ----- src/mcct_back.sv -----
// Timer engine: holds the timer table and carries out queued commands.
// A tick walks the allocated timers one per cycle, pausing at an expiry while the output stalls. Uses mcct_pkg.
module mcct_back
	import mcct_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	input  queue_status_t       q_status,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [KIND_W-1:0]   kind,
	output logic [HANDLE_W-1:0] timer_index,
	output logic [DATA_W-1:0]   value,
	output logic                last
);

	back_state_t       state_q, state_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic              armed_q [TIMER_COUNT];
	logic              single_q [TIMER_COUNT];
	logic [DATA_W-1:0] rem_q [TIMER_COUNT];
	logic [DATA_W-1:0] reload_q [TIMER_COUNT];
	logic [CNT_W-1:0]  alloc_q;
	logic [DATA_W-1:0] ticks_q;
	logic              out_valid_q;
	logic [KIND_W-1:0] kind_q;
	logic [HANDLE_W-1:0] index_q;
	logic [DATA_W-1:0] value_q;
	logic              last_q;

	logic              can_emit;
	logic [IDX_W-1:0]  addr;
	logic [DATA_W-1:0] rd_rem;
	logic [DATA_W-1:0] rd_reload;
	logic [DATA_W-1:0] dec;
	logic              active;
	logic              expire;
	logic              later;
	logic [TIMER_COUNT-1:0] exp_vec;
	logic              emit;
	logic [KIND_W-1:0] e_kind;
	logic [HANDLE_W-1:0] e_index;
	logic [DATA_W-1:0] e_value;
	logic              e_last;
	logic              rem_we;
	logic [DATA_W-1:0] rem_wd;
	logic              reload_we;
	logic              armed_we;
	logic              armed_wd;
	logic              single_we;
	logic              alloc_inc;
	logic              tick_inc;

	always_comb begin
		can_emit = !out_valid_q || !out_stall;
		addr = (state_q == ST_WALK) ? idx_q : cmd.idx;
		rd_rem = rem_q[addr];
		rd_reload = reload_q[addr];
		dec = rd_rem - DATA_W'(1);
		active = armed_q[addr];
		expire = active && (dec == '0);
		for (int i = 0; i < TIMER_COUNT; i++) begin
			exp_vec[i] = (CNT_W'(i) < alloc_q) && armed_q[i] && (rem_q[i] == DATA_W'(1));
		end
		later = 1'b0;
		for (int i = 0; i < TIMER_COUNT; i++) begin
			later = later || (exp_vec[i] && (IDX_W'(i) > idx_q));
		end
	end

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		pop = 1'b0;
		emit = 1'b0;
		e_kind = KIND_EXPIRY;
		e_index = '0;
		e_value = '0;
		e_last = 1'b1;
		rem_we = 1'b0;
		rem_wd = rd_reload;
		reload_we = 1'b0;
		armed_we = 1'b0;
		armed_wd = 1'b0;
		single_we = 1'b0;
		alloc_inc = 1'b0;
		tick_inc = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_status.not_empty && can_emit) begin
					pop = 1'b1;
					case (cmd.op)
						OP_TICK: begin
							tick_inc = 1'b1;
							if (alloc_q != '0) begin
								state_d = ST_WALK;
								idx_d = '0;
							end
						end
						OP_ALLOC: begin
							emit = 1'b1;
							if (alloc_q < CNT_W'(TIMER_COUNT)) begin
								e_kind = KIND_GRANT;
								e_index = HANDLE_W'(alloc_q);
								alloc_inc = 1'b1;
							end else begin
								e_kind = KIND_REFUSE;
							end
						end
						OP_SET: begin
							single_we = 1'b1;
							rem_we = 1'b1;
							rem_wd = cmd.period;
							reload_we = 1'b1;
						end
						OP_START: begin
							rem_we = 1'b1;
							armed_we = 1'b1;
							armed_wd = 1'b1;
						end
						OP_STOP: begin
							armed_we = 1'b1;
						end
						OP_RESET: begin
							rem_we = 1'b1;
							armed_we = 1'b1;
						end
						OP_READ: begin
							emit = 1'b1;
							e_kind = KIND_TICKS;
							e_value = ticks_q;
						end
						default: begin
						end
					endcase
				end
			end
			ST_WALK: begin
				if (!expire || can_emit) begin
					if (active) begin
						rem_we = 1'b1;
						rem_wd = expire ? rd_reload : dec;
					end
					if (expire) begin
						emit = 1'b1;
						e_kind = KIND_EXPIRY;
						e_index = HANDLE_W'(idx_q);
						e_last = !later;
						armed_we = single_q[idx_q];
					end
					if (CNT_W'(idx_q) + CNT_W'(1) >= alloc_q) begin
						state_d = ST_IDLE;
					end else begin
						idx_d = idx_q + IDX_W'(1);
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			alloc_q <= '0;
			ticks_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < TIMER_COUNT; i++) begin
				armed_q[i] <= 1'b0;
				single_q[i] <= 1'b0;
				rem_q[i] <= '0;
				reload_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			if (alloc_inc) begin
				alloc_q <= alloc_q + CNT_W'(1);
			end
			if (tick_inc) begin
				ticks_q <= ticks_q + DATA_W'(1);
			end
			if (rem_we) begin
				rem_q[addr] <= rem_wd;
			end
			if (reload_we) begin
				reload_q[addr] <= cmd.period;
			end
			if (armed_we) begin
				armed_q[addr] <= armed_wd;
			end
			if (single_we) begin
				single_q[addr] <= cmd.one_shot;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q <= e_kind;
			index_q <= e_index;
			value_q <= e_value;
			last_q <= e_last;
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign timer_index = index_q;
	assign value = value_q;
	assign last = last_q;

endmodule

// ----- src/multi_channel_countdown_timers.sv -----
// Top level of the multi-channel countdown timer block.
// Instantiates mcct_front, mcct_queue and mcct_back; uses mcct_pkg.
//
// Each input request is one command: tick, allocate, set, start, stop, reset
// or read the tick counter. Requests enter on in_valid/in_stall and go into a
// two-entry command queue, so in_stall rises only when that queue is full.
// Commands with an out-of-range handle and the unused mode are dropped.
// Results leave on out_valid/out_stall from an output register.
// The engine carries out a non-tick command from the queue head while it is
// idle and no result is held stalled, and registers its result, if any, in the
// output register; with no stall one such request is taken per cycle.
// A tick walks the allocated timers, if any, one table entry per cycle while
// not halted by a stall; it emits one expiry per expired timer with last set
// on the final one.
// While the receiver stalls, the held result stays put. The engine starts no
// new command and halts a tick walk at its next expiry until the held result
// is taken; requests keep queueing until the queue is full.
// Reset is asynchronous: it clears the whole timer table, the handle count,
// the tick counter and the queue, and drops any result not yet taken.
module multi_channel_countdown_timers
	import mcct_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [MODE_W-1:0]   mode,
	input  logic [HANDLE_W-1:0] handle,
	input  logic [DATA_W-1:0]   period,
	input  logic                one_shot,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [KIND_W-1:0]   kind,
	output logic [HANDLE_W-1:0] timer_index,
	output logic [DATA_W-1:0]   value,
	output logic                last
);

	queue_status_t q_status;
	logic          push;
	cmd_t          push_cmd;
	logic          pop;
	cmd_t          head;

	mcct_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.handle   (handle),
		.period   (period),
		.one_shot (one_shot),
		.q_status (q_status),
		.push     (push),
		.push_cmd (push_cmd)
	);

	mcct_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	mcct_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (head),
		.q_status    (q_status),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.timer_index (timer_index),
		.value       (value),
		.last        (last)
	);

endmodule

// ----- src/mcct_checker.sv -----
// Port-level checks for the multi-channel countdown timer block.
// Bound to multi_channel_countdown_timers; uses mcct_pkg.
module mcct_checker
	import mcct_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input logic [KIND_W-1:0]   kind,
	input logic [HANDLE_W-1:0] timer_index,
	input logic [DATA_W-1:0]   value,
	input logic                last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(timer_index)
			&& $stable(value) && $stable(last))
		else $error("Stalled result changed.");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != KIND_TICKS) |-> value == '0)
		else $error("Value nonzero on a result other than a tick count.");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != KIND_EXPIRY) |-> last)
		else $error("Single result of a request not marked last.");

	a_refuse_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_REFUSE || kind == KIND_TICKS) |-> timer_index == '0)
		else $error("Refusal or tick count carries a timer index.");

endmodule

bind multi_channel_countdown_timers mcct_checker u_mcct_checker (.*);
